// ===== rtl/esht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esht_pkg
// Types and constants shared by the sensor edge health test block.
// ----------------------------------------------------------------------------
package esht_pkg;

	localparam int SAMPLE_FIELDS = 7;
	localparam int LANE_SLOTS    = 16;
	localparam int EDGE_W        = 7;
	localparam int FAIL_W        = 5;
	localparam int CNT_W         = 32;
	localparam int CFG_IDX_W     = 8;
	localparam int CFG_DATA_W    = 7;

	localparam logic [EDGE_W-1:0]    EDGE_MAX   = 7'd127;
	localparam logic [6:0]           ALARM_BIAS = 7'd100;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_EDGES = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_EDGES = 8'd1;
	localparam logic                 FUNC_TICK  = 1'b0;
	localparam logic                 FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] sample_a;
		logic [7:0] sample_b;
		logic [7:0] sample_c;
		logic [7:0] sample_d;
		logic [7:0] sample_e;
		logic [7:0] sample_f;
		logic [7:0] sample_g;
	} req_item_t;

	typedef struct packed {
		logic             window_done;
		logic [6:0]       pass_mask;
		logic             health_alarm;
		logic [CNT_W-1:0] tests_seen;
		logic [CNT_W-1:0] tests_failed;
	} rsp_item_t;

	typedef struct packed {
		logic                  done;
		logic [LANE_SLOTS-1:0] pass;
		logic [FAIL_W-1:0]     fails;
	} win_res_t;

	typedef struct packed {
		logic             alarm;
		logic [CNT_W-1:0] tests;
		logic [CNT_W-1:0] fails;
	} cnt_res_t;

endpackage
`default_nettype wire

// ===== rtl/esht_lanes.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esht_lanes
// Per-lane rising and falling edge counters over one sample window, with the
// pass check at the tick that closes the window.
// ----------------------------------------------------------------------------
module esht_lanes #(
	parameter int WINDOW_LEN = 128,
	parameter int LANES      = 7
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 tick,
	input  wire logic [esht_pkg::SAMPLE_FIELDS-1:0]   low_bits,
	input  wire logic [esht_pkg::EDGE_W-1:0]          min_edges,
	input  wire logic [esht_pkg::EDGE_W-1:0]          max_edges,
	output esht_pkg::win_res_t                        win
);
	import esht_pkg::*;

	localparam int PW = (WINDOW_LEN > 2) ? $clog2(WINDOW_LEN) : 1;

	logic [PW-1:0]     pos_q;
	logic [LANES-1:0]  prev_q;
	logic [EDGE_W-1:0] rise_q [LANES];
	logic [EDGE_W-1:0] fall_q [LANES];

	logic [LANES-1:0]  cur_bits;
	logic [EDGE_W-1:0] rise_nx [LANES];
	logic [EDGE_W-1:0] fall_nx [LANES];
	logic [LANES-1:0]  pass_w;
	logic              close_w;

	assign close_w = (pos_q == PW'(WINDOW_LEN - 1));

	always_comb begin
		logic [EDGE_W-1:0] lo;
		logic [EDGE_W-1:0] hi;
		for (int i = 0; i < LANES; i++) begin
			cur_bits[i] = (i < SAMPLE_FIELDS) ? low_bits[i % SAMPLE_FIELDS] : 1'b0;
			rise_nx[i] = rise_q[i];
			fall_nx[i] = fall_q[i];
			if (pos_q != '0) begin
				if (!prev_q[i] && cur_bits[i] && rise_q[i] != EDGE_MAX) begin
					rise_nx[i] = rise_q[i] + 1'b1;
				end
				if (prev_q[i] && !cur_bits[i] && fall_q[i] != EDGE_MAX) begin
					fall_nx[i] = fall_q[i] + 1'b1;
				end
			end
			lo = (rise_nx[i] < fall_nx[i]) ? rise_nx[i] : fall_nx[i];
			hi = (rise_nx[i] < fall_nx[i]) ? fall_nx[i] : rise_nx[i];
			pass_w[i] = (lo >= min_edges) && (hi <= max_edges);
		end
	end

	always_comb begin
		win.done  = tick && close_w;
		win.pass  = '0;
		win.fails = FAIL_W'($countones(~pass_w));
		if (win.done) begin
			win.pass[LANES-1:0] = pass_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			prev_q <= '0;
			for (int i = 0; i < LANES; i++) begin
				rise_q[i] <= '0;
				fall_q[i] <= '0;
			end
		end else if (tick) begin
			prev_q <= cur_bits;
			if (close_w) begin
				pos_q <= '0;
				for (int i = 0; i < LANES; i++) begin
					rise_q[i] <= '0;
					fall_q[i] <= '0;
				end
			end else begin
				pos_q <= pos_q + 1'b1;
				for (int i = 0; i < LANES; i++) begin
					rise_q[i] <= rise_nx[i];
					fall_q[i] <= fall_nx[i];
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/esht_counters.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esht_counters
// Saturating test and failure totals and the one percent alarm check.
// ----------------------------------------------------------------------------
module esht_counters #(
	parameter int LANES = 7
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                tick,
	input  wire logic                query,
	input  wire esht_pkg::win_res_t  win,
	output esht_pkg::cnt_res_t       res
);
	import esht_pkg::*;

	logic [CNT_W-1:0] tests_q;
	logic [CNT_W-1:0] fails_q;
	logic [CNT_W:0]   tests_sum;
	logic [CNT_W:0]   fails_sum;
	logic [CNT_W-1:0] tests_nx;
	logic [CNT_W-1:0] fails_nx;
	logic [CNT_W+7:0] bias_sum;
	logic [CNT_W+7:0] fails_scaled;
	logic             alarm_w;

	// fails > (tests + 100) / 100  is the same as  tests + 100 < 100 * fails
	assign bias_sum     = (CNT_W+8)'(tests_q) + (CNT_W+8)'(ALARM_BIAS);
	assign fails_scaled = (CNT_W+8)'(fails_q) * (CNT_W+8)'(ALARM_BIAS);
	assign alarm_w      = bias_sum < fails_scaled;

	assign tests_sum = (CNT_W+1)'(tests_q) + (CNT_W+1)'(LANES);
	assign fails_sum = (CNT_W+1)'(fails_q) + (CNT_W+1)'(win.fails);
	assign tests_nx  = tests_sum[CNT_W] ? '1 : tests_sum[CNT_W-1:0];
	assign fails_nx  = fails_sum[CNT_W] ? '1 : fails_sum[CNT_W-1:0];

	always_comb begin
		res.alarm = query && alarm_w;
		if (query) begin
			res.tests = tests_q;
			res.fails = fails_q;
		end else if (win.done) begin
			res.tests = tests_nx;
			res.fails = fails_nx;
		end else begin
			res.tests = tests_q;
			res.fails = fails_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tests_q <= '0;
			fails_q <= '0;
		end else if (query && alarm_w) begin
			tests_q <= '0;
			fails_q <= '0;
		end else if (tick && win.done) begin
			tests_q <= tests_nx;
			fails_q <= fails_nx;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/entropy_sensor_edge_health_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// entropy_sensor_edge_health_test
// Continuous edge-count health test over seven sensor lanes, with a status
// query that reports the saturating test and failure totals and clears them on alarm.
// An accepted item passes the input register, then the result register drives it.
// Throughput: one item per cycle while the receiver does not stall the result.
// Reset clears the window, edge counters and totals; thresholds return to 16/48.
// ----------------------------------------------------------------------------
module entropy_sensor_edge_health_test #(
	parameter int WINDOW_LEN = 128,
	parameter int LANES      = 7
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire esht_pkg::req_item_t               req_data,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output esht_pkg::rsp_item_t                    rsp_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [esht_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [esht_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import esht_pkg::*;

	req_item_t         item_s1;
	logic              valid_s1;
	rsp_item_t         rsp_q;
	logic              rsp_valid_q;
	logic [EDGE_W-1:0] min_edges_q;
	logic [EDGE_W-1:0] max_edges_q;

	logic                     adv;
	logic                     fire;
	logic                     tick;
	logic                     query;
	logic [SAMPLE_FIELDS-1:0] low_bits;
	win_res_t                 win;
	cnt_res_t                 cres;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign fire      = valid_s1 && adv;
	assign tick      = fire && (item_s1.func == FUNC_TICK);
	assign query     = fire && (item_s1.func == FUNC_QUERY);
	assign req_stall = valid_s1 && !adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign cfg_ready = 1'b1;

	assign low_bits = {item_s1.sample_g[0], item_s1.sample_f[0], item_s1.sample_e[0],
		item_s1.sample_d[0], item_s1.sample_c[0], item_s1.sample_b[0],
		item_s1.sample_a[0]};

	esht_lanes #(
		.WINDOW_LEN(WINDOW_LEN),
		.LANES     (LANES)
	) u_lanes (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.low_bits (low_bits),
		.min_edges(min_edges_q),
		.max_edges(max_edges_q),
		.win      (win)
	);

	esht_counters #(
		.LANES(LANES)
	) u_counters (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick),
		.query (query),
		.win   (win),
		.res   (cres)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_edges_q <= 7'd16;
			max_edges_q <= 7'd48;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_EDGES: min_edges_q <= cfg_data;
				REG_MAX_EDGES: max_edges_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			item_s1 <= req_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.window_done  <= tick && win.done;
			rsp_q.pass_mask    <= tick ? win.pass[6:0] : 7'd0;
			rsp_q.health_alarm <= cres.alarm;
			rsp_q.tests_seen   <= cres.tests;
			rsp_q.tests_failed <= cres.fails;
		end
	end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sensor edge health test block. A queue of sensor
// ticks and status queries feeds a clocked driver; a clocked monitor checks
// every result item against an in-bench prediction of the edge counters,
// windows and saturating totals. Threshold registers are rewritten between
// phases, both sides idle and stall at random, and one long receiver hold
// pushes back on the input.
// ----------------------------------------------------------------------------
module testbench;
	import esht_pkg::*;

	localparam int WINDOW_LEN = 128;
	localparam int LANES      = 7;
	localparam int LATENCY    = 2;
	localparam int EDGE_SAT   = 127;
	localparam int PHASES     = 8;
	localparam int LIMIT_NS   = 10_000_000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_item_t             req_data  = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_item_t             rsp_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	entropy_sensor_edge_health_test #(
		.WINDOW_LEN(WINDOW_LEN),
		.LANES(LANES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted block state
	logic [6:0]  thr_min = 7'd16;
	logic [6:0]  thr_max = 7'd48;
	int          win_pos;
	logic [6:0]  prev_bits;
	int          rise_cnt [LANES];
	int          fall_cnt [LANES];
	logic [31:0] test_total;
	logic [31:0] fail_total;

	// stimulus state
	logic [6:0]  gen_bits;
	int          flip_rate [SAMPLE_FIELDS];

	req_item_t   sensor_items [$];
	rsp_item_t   health_reports [$];
	rsp_item_t   want;

	logic        req_fire = 1'b0;
	int          gap_left = 0;
	int          burst_left = 0;
	int          stall_left = 0;
	int          run_left = 0;
	int          long_hold_left = 0;
	logic        long_hold_done = 1'b0;

	int          mismatches = 0;
	int          items_sent = 0;
	int          queries_sent = 0;
	int          results_checked = 0;
	int          windows_closed = 0;
	int          alarms_raised = 0;
	int          settings_used = 1;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		mismatches++;
		if (mismatches <= 20)
			$display("%0t mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
	endtask

	function automatic int pick_idle();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 96)
			return $urandom_range(12, 4);
		return $urandom_range(60, 25);
	endfunction

	function automatic rsp_item_t health_update(req_item_t it);
		rsp_item_t  r;
		logic [6:0] cur;
		logic [63:0] limit;
		logic [32:0] sum;
		int         i, lo, hi, fails;
		r = '0;
		if (it.func == FUNC_QUERY) begin
			queries_sent++;
			limit = ({32'd0, test_total} + 64'd100) / 64'd100;
			r.tests_seen = test_total;
			r.tests_failed = fail_total;
			if ({32'd0, fail_total} > limit) begin
				r.health_alarm = 1'b1;
				test_total = '0;
				fail_total = '0;
				alarms_raised++;
			end
		end else begin
			cur = {it.sample_g[0], it.sample_f[0], it.sample_e[0], it.sample_d[0],
				it.sample_c[0], it.sample_b[0], it.sample_a[0]};
			if (win_pos != 0) begin
				for (i = 0; i < LANES; i++) begin
					if (!prev_bits[i] && cur[i] && rise_cnt[i] < EDGE_SAT)
						rise_cnt[i]++;
					if (prev_bits[i] && !cur[i] && fall_cnt[i] < EDGE_SAT)
						fall_cnt[i]++;
				end
			end
			prev_bits = cur;
			win_pos++;
			if (win_pos >= WINDOW_LEN) begin
				fails = 0;
				for (i = 0; i < LANES; i++) begin
					lo = (rise_cnt[i] < fall_cnt[i]) ? rise_cnt[i] : fall_cnt[i];
					hi = (rise_cnt[i] < fall_cnt[i]) ? fall_cnt[i] : rise_cnt[i];
					if (lo >= int'(thr_min) && hi <= int'(thr_max))
						r.pass_mask[i] = 1'b1;
					else
						fails++;
					rise_cnt[i] = 0;
					fall_cnt[i] = 0;
				end
				sum = {1'b0, test_total} + 33'(LANES);
				test_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				sum = {1'b0, fail_total} + 33'(fails);
				fail_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				win_pos = 0;
				r.window_done = 1'b1;
				windows_closed++;
			end
			r.tests_seen = test_total;
			r.tests_failed = fail_total;
		end
		return r;
	endfunction

	function automatic req_item_t make_tick();
		req_item_t  it;
		logic [7:0] b [SAMPLE_FIELDS];
		int         i;
		for (i = 0; i < SAMPLE_FIELDS; i++) begin
			b[i] = 8'($urandom_range(255));
			if ($urandom_range(999) < flip_rate[i])
				gen_bits[i] = ~gen_bits[i];
			b[i][0] = gen_bits[i];
		end
		it = '{FUNC_TICK, b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
		return it;
	endfunction

	function automatic req_item_t fill_tick(logic [7:0] v);
		req_item_t it;
		it = '{FUNC_TICK, v, v, v, v, v, v, v};
		return it;
	endfunction

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MIN_EDGES)
			thr_min = val;
		else if (idx == REG_MAX_EDGES)
			thr_max = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (sensor_items.size() != 0 || req_valid || health_reports.size() != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_fire) begin
			if (gap_left > 0) begin
				req_valid <= 1'b0;
				gap_left--;
			end else if (sensor_items.size() != 0) begin
				req_data <= sensor_items.pop_front();
				req_valid <= 1'b1;
				if (long_hold_left > 0 || burst_left > 0) begin
					gap_left = 0;
					if (burst_left > 0)
						burst_left--;
				end else if ($urandom_range(49) == 0) begin
					burst_left = $urandom_range(100, 30);
				end else begin
					gap_left = pick_idle();
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (long_hold_left > 0) begin
			rsp_stall <= 1'b1;
			long_hold_left--;
		end else if (!long_hold_done && results_checked >= 400 && sensor_items.size() >= 60) begin
			long_hold_done = 1'b1;
			long_hold_left = 299;
			rsp_stall <= 1'b1;
		end else if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else if (run_left > 0) begin
			rsp_stall <= 1'b0;
			run_left--;
		end else begin
			rsp_stall <= 1'b0;
			stall_left = pick_idle();
			run_left = ($urandom_range(19) == 0) ? $urandom_range(120, 40) : $urandom_range(8);
		end
	end

	// prediction on accept, check on result
	always @(posedge clk) begin
		if (!arst_n) begin
			req_fire = 1'b0;
		end else begin
			req_fire = req_valid && !req_stall;
			if (req_fire) begin
				health_reports.push_back(health_update(req_data));
				items_sent++;
			end
			if (rsp_valid && !rsp_stall) begin
				results_checked++;
				if (health_reports.size() == 0) begin
					report_mismatch("unexpected item", rsp_data.tests_seen, '0);
				end else begin
					want = health_reports.pop_front();
					if (rsp_data.window_done !== want.window_done)
						report_mismatch("window_done", 32'(rsp_data.window_done),
							32'(want.window_done));
					if (rsp_data.pass_mask !== want.pass_mask)
						report_mismatch("pass_mask", 32'(rsp_data.pass_mask),
							32'(want.pass_mask));
					if (rsp_data.health_alarm !== want.health_alarm)
						report_mismatch("health_alarm", 32'(rsp_data.health_alarm),
							32'(want.health_alarm));
					if (rsp_data.tests_seen !== want.tests_seen)
						report_mismatch("tests_seen", rsp_data.tests_seen, want.tests_seen);
					if (rsp_data.tests_failed !== want.tests_failed)
						report_mismatch("tests_failed", rsp_data.tests_failed,
							want.tests_failed);
				end
			end
		end
	end

	initial begin
		int         p, k, n, i;
		req_item_t  it;
		logic [6:0] mn, mx;
		win_pos = 0;
		prev_bits = '0;
		test_total = '0;
		fail_total = '0;
		gen_bits = '0;
		for (i = 0; i < LANES; i++) begin
			rise_cnt[i] = 0;
			fall_cnt[i] = 0;
		end
		for (i = 0; i < SAMPLE_FIELDS; i++)
			flip_rate[i] = 500;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// query on empty totals, edge directions, query mid-window
		sensor_items.push_back('{FUNC_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
		sensor_items.push_back(fill_tick(8'h00));
		sensor_items.push_back(fill_tick(8'hFF));
		sensor_items.push_back(fill_tick(8'hFE));
		sensor_items.push_back(fill_tick(8'h01));
		sensor_items.push_back(fill_tick(8'h80));
		sensor_items.push_back(fill_tick(8'h7F));
		sensor_items.push_back('{FUNC_TICK, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55});
		sensor_items.push_back('{FUNC_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		sensor_items.push_back('{FUNC_TICK, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA});
		sensor_items.push_back(fill_tick(8'h00));
		sensor_items.push_back('{FUNC_QUERY, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40});

		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
				0: begin mn = thr_min; mx = thr_max; end
				1: begin mn = 7'd0;   mx = 7'd127; end
				2: begin mn = 7'd127; mx = 7'd0;   end
				3: begin mn = 7'd0;   mx = 7'd0;   end
				4: begin mn = 7'd127; mx = 7'd127; end
				5: begin mn = 7'd16;  mx = 7'd48;  end
				default: begin
					mn = 7'($urandom_range(40));
					mx = 7'($urandom_range(127, 20));
				end
			endcase
			if (p != 0) begin
				cfg_write(REG_MIN_EDGES, mn);
				cfg_write(REG_MAX_EDGES, mx);
				settings_used++;
			end
			// writes to unused register indexes must be ignored
			if (p == 1) begin
				cfg_write(8'd2, 7'h7F);
				cfg_write(8'hFF, 7'h00);
			end else if (p > 1 && $urandom_range(2) == 0) begin
				cfg_write(8'($urandom_range(255, 2)), 7'($urandom_range(127)));
			end
			n = $urandom_range(150, 115);
			for (k = 0; k < n; k++) begin
				if (k % 64 == 0) begin
					for (i = 0; i < SAMPLE_FIELDS; i++) begin
						case ($urandom_range(7))
							0: flip_rate[i] = 0;
							1: flip_rate[i] = 20;
							2: flip_rate[i] = 100;
							3: flip_rate[i] = 250;
							4: flip_rate[i] = 500;
							5: flip_rate[i] = 750;
							6: flip_rate[i] = 950;
							default: flip_rate[i] = 1000;
						endcase
					end
				end
				it = make_tick();
				if ($urandom_range(99) < 4)
					it.func = FUNC_QUERY;
				sensor_items.push_back(it);
			end
		end

		wait_drained();
		repeat (LATENCY + 8) @(posedge clk);
		if (health_reports.size() != 0)
			report_mismatch("missing items", health_reports.size(), '0);
		$display("covered %0d items (%0d queries), %0d results, %0d closed windows, %0d alarms",
			items_sent, queries_sent, results_checked, windows_closed, alarms_raised);
		$display("threshold settings used: %0d, long receiver hold: %0d, mismatches: %0d",
			settings_used, long_hold_done, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("timeout after %0d ns", LIMIT_NS);
		$display("Regression FAIL");
		$finish;
	end

endmodule
